// File: design/rsb_pkg.sv
// shared types, codes and widths for the restart supervisor with backoff
// no dependencies; every other design file refers to it by scoped names
package rsb_pkg;

  localparam int TIME_BITS      = 48;
  localparam int COUNT_BITS     = 8;
  localparam int CFG_BITS       = 32;
  localparam int LIMIT_BITS     = 8;
  localparam int CFG_INDEX_BITS = 2;

  // event codes carried in the opcode field; code 7 has no meaning
  typedef enum logic [2:0] {
    OP_START          = 3'd0,
    OP_STARTED        = 3'd1,
    OP_HS_OK          = 3'd2,
    OP_HS_REJECT      = 3'd3,
    OP_STOP           = 3'd4,
    OP_EXITED         = 3'd5,
    OP_RESET_DISABLED = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    PH_STOPPED     = 3'd0,
    PH_STARTING    = 3'd1,
    PH_HANDSHAKING = 3'd2,
    PH_RUNNING     = 3'd3,
    PH_STOPPING    = 3'd4,
    PH_BACKOFF     = 3'd5,
    PH_DISABLED    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_POLICY    = 3'd1,
    ST_PENDING   = 3'd2,
    ST_WRONG     = 3'd3,
    ST_STOPPING  = 3'd4,
    ST_SCHEDULED = 3'd5,
    ST_DISABLED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_LAUNCH    = 3'd1,
    ACT_AWAIT     = 3'd2,
    ACT_TERMINATE = 3'd3,
    ACT_RESTART   = 3'd4
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BASE   = 2'd0,
    CFG_MAX    = 2'd1,
    CFG_STABLE = 2'd2,
    CFG_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [TIME_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [2:0]            status;
    logic [2:0]            state_now;
    logic [2:0]            action;
    logic [TIME_BITS-1:0]  retry_at_ms;
    logic                  retry_valid;
    logic [COUNT_BITS-1:0] failure_count;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    take;
    logic    clr_retry;
    logic    set_run;
    logic    clr_run;
    logic    set_dos;
    logic    clr_dos;
    logic    clr_fail;
    logic    count_fail;
    logic    stable_clr;
    logic    delay_init;
    logic    delay_step;
    logic    set_retry;
    logic    load_out;
    phase_t  res_phase;
    logic    res_acc;
    status_t res_st;
    action_t res_act;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       policy_ok;
    logic       pending;
    logic       stable_run;
    logic       dos;
    logic       fail_hit;
    logic       delay_done;
  } sts_t;

endpackage

// File: design/restart_supervisor_backoff_top.sv
// top level of the restart supervisor with exponential backoff
// depends on rsb_pkg, rsb_ctrl and rsb_datapath
//
// usage: one lifecycle event (opcode, now_ms) is a beat on the in channel;
// each event yields exactly one result beat on the out channel with the
// accept flag, status, phase after the event, action, retry time and count.
// the cfg channel writes the four policy registers by index (base, max,
// stable runtime, crash limit); it is always ready; the user must write it only
// while idle, the block itself does not enforce this. an event is latched,
// decoded and its result loaded into the output register; an exit after a
// crash also passes a crash-limit check, and one that schedules a restart then
// passes the backoff doubling steps, at most min(failures-1, 32) doublings.
// one event is processed at a time; the next is taken once the current
// result sits in the output register, so a stalled receiver holds one result
// while the next event is processed, then stalls intake.
// reset: phase stopped, failures and retry cleared, policy registers at
// 1000 / 60000 / 30000 / 5.
module restart_supervisor_backoff_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rsb_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rsb_pkg::out_item_t                   out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_BITS-1:0]         cfg_data
);

  rsb_pkg::cmd_t cmd;
  rsb_pkg::sts_t sts;

  // sequencer and supervisor phase
  rsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // counters, timers, policy registers and output beat
  rsb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

// File: design/rsb_datapath.sv
// datapath: config registers, event latch, failure counter, retry time,
// backoff doubling unit and output beat register; depends on rsb_pkg
module rsb_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rsb_pkg::in_item_t                    in_item,
  input  rsb_pkg::cmd_t                        cmd,
  output rsb_pkg::sts_t                        sts,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_BITS-1:0]         cfg_data,
  output rsb_pkg::out_item_t                   out_item
);

  localparam int TB = rsb_pkg::TIME_BITS;
  localparam int CB = rsb_pkg::CFG_BITS;
  localparam int NB = rsb_pkg::COUNT_BITS;

  logic [CB-1:0]                  base_cfg;
  logic [CB-1:0]                  max_cfg;
  logic [CB-1:0]                  stable_cfg;
  logic [rsb_pkg::LIMIT_BITS-1:0] limit_cfg;

  logic [2:0]    op_q;
  logic [TB-1:0] now_q;

  logic [NB-1:0] failures;
  logic [TB-1:0] retry_time;
  logic          retry_set;
  logic [TB-1:0] run_start;
  logic          run_set;
  logic          dos;

  logic [CB-1:0] dly;
  logic [NB-1:0] dly_k;

  logic [CB:0]   dly_dbl;
  logic [CB-1:0] dly_next;
  logic [TB:0]   retry_sum;
  logic [TB-1:0] retry_sat;
  logic [TB-1:0] run_len;
  logic [NB-1:0] fail_base;
  logic [NB-1:0] fail_next;

  assign cfg_ready = 1'b1;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_cfg   <= CB'(1000);
      max_cfg    <= CB'(60000);
      stable_cfg <= CB'(30000);
      limit_cfg  <= rsb_pkg::LIMIT_BITS'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (rsb_pkg::cfg_reg_t'(cfg_index))
        rsb_pkg::CFG_BASE:   base_cfg   <= cfg_data;
        rsb_pkg::CFG_MAX:    max_cfg    <= cfg_data;
        rsb_pkg::CFG_STABLE: stable_cfg <= cfg_data;
        rsb_pkg::CFG_LIMIT:  limit_cfg  <= cfg_data[rsb_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // doubling step, capped at the maximum delay
  assign dly_dbl  = {dly, 1'b0};
  assign dly_next = (dly_dbl < {1'b0, max_cfg}) ? dly_dbl[CB-1:0] : max_cfg;

  // retry time, saturating at the top of the time range
  assign retry_sum = {1'b0, now_q} + {{(TB-CB+1){1'b0}}, dly};
  assign retry_sat = retry_sum[TB] ? {TB{1'b1}} : retry_sum[TB-1:0];

  // failure count after an exit, with the stable-run clear first
  assign fail_base = cmd.stable_clr ? '0 : failures;
  assign fail_next = (fail_base == {NB{1'b1}}) ? fail_base : NB'(fail_base + 1'b1);

  assign run_len = now_q - run_start;

  // status toward the controller
  always_comb begin
    sts.opcode     = op_q;
    sts.policy_ok  = (base_cfg != '0) && (max_cfg >= base_cfg) && (limit_cfg != '0);
    sts.pending    = retry_set && (now_q < retry_time);
    sts.stable_run = run_set && (now_q >= run_start)
                     && (run_len >= {{(TB-CB){1'b0}}, stable_cfg});
    sts.dos        = dos;
    sts.fail_hit   = failures >= limit_cfg;
    sts.delay_done = (dly_k >= failures) || (dly >= max_cfg) || (dly == '0);
  end

  // event latch and backoff iteration registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= in_item.opcode;
      now_q <= in_item.now_ms;
    end
    if (cmd.delay_init) begin
      dly   <= base_cfg;
      dly_k <= NB'(1);
    end else if (cmd.delay_step) begin
      dly   <= dly_next;
      dly_k <= NB'(dly_k + 1'b1);
    end
  end

  // supervisor state held in the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      failures   <= '0;
      retry_time <= '0;
      retry_set  <= 1'b0;
      run_start  <= '0;
      run_set    <= 1'b0;
      dos        <= 1'b0;
    end else begin
      if (cmd.count_fail) begin
        failures <= fail_next;
      end else if (cmd.clr_fail) begin
        failures <= '0;
      end
      if (cmd.set_retry) begin
        retry_time <= retry_sat;
        retry_set  <= 1'b1;
      end else if (cmd.clr_retry) begin
        retry_time <= '0;
        retry_set  <= 1'b0;
      end
      if (cmd.set_run) begin
        run_start <= now_q;
        run_set   <= 1'b1;
      end else if (cmd.clr_run) begin
        run_set   <= 1'b0;
      end
      if (cmd.set_dos) begin
        dos <= 1'b1;
      end else if (cmd.clr_dos) begin
        dos <= 1'b0;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.accepted      <= cmd.res_acc;
      out_item.status        <= cmd.res_st;
      out_item.state_now     <= cmd.res_phase;
      out_item.action        <= cmd.res_act;
      out_item.retry_at_ms   <= retry_set ? retry_time : '0;
      out_item.retry_valid   <= retry_set;
      out_item.failure_count <= failures;
    end
  end

endmodule

// File: design/rsb_ctrl.sv
// controller: supervisor phase, per-event sequencer and output beat valid
// depends on rsb_pkg; drives the datapath through rsb_pkg::cmd_t
module rsb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rsb_pkg::sts_t sts,
  output rsb_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LIMIT,
    S_DELAY,
    S_DONE
  } state_t;

  state_t           state, state_next;
  rsb_pkg::phase_t  phase, phase_next;
  logic             res_acc, res_acc_next;
  rsb_pkg::status_t res_st, res_st_next;
  rsb_pkg::action_t res_act, res_act_next;

  // sequencer and event decode
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_next    = state;
    phase_next    = phase;
    res_acc_next  = res_acc;
    res_st_next   = res_st;
    res_act_next  = res_act;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_acc_next = 1'b0;
        res_st_next  = rsb_pkg::ST_WRONG;
        res_act_next = rsb_pkg::ACT_NONE;
        state_next   = S_DONE;
        case (rsb_pkg::opcode_t'(sts.opcode))
          rsb_pkg::OP_START: begin
            if (!sts.policy_ok) begin
              res_st_next = rsb_pkg::ST_POLICY;
            end else if (phase == rsb_pkg::PH_BACKOFF && sts.pending) begin
              res_st_next  = rsb_pkg::ST_PENDING;
              res_act_next = rsb_pkg::ACT_RESTART;
            end else if (phase inside {rsb_pkg::PH_STOPPED, rsb_pkg::PH_BACKOFF}) begin
              phase_next    = rsb_pkg::PH_STARTING;
              cmd.clr_retry = 1'b1;
              res_acc_next  = 1'b1;
              res_st_next   = rsb_pkg::ST_OK;
              res_act_next  = rsb_pkg::ACT_LAUNCH;
            end
          end
          rsb_pkg::OP_STARTED: begin
            if (phase == rsb_pkg::PH_STARTING) begin
              phase_next   = rsb_pkg::PH_HANDSHAKING;
              res_acc_next = 1'b1;
              res_st_next  = rsb_pkg::ST_OK;
              res_act_next = rsb_pkg::ACT_AWAIT;
            end
          end
          rsb_pkg::OP_HS_OK: begin
            if (phase == rsb_pkg::PH_HANDSHAKING) begin
              phase_next   = rsb_pkg::PH_RUNNING;
              cmd.set_run  = 1'b1;
              res_acc_next = 1'b1;
              res_st_next  = rsb_pkg::ST_OK;
            end
          end
          rsb_pkg::OP_HS_REJECT: begin
            if (phase == rsb_pkg::PH_HANDSHAKING) begin
              phase_next   = rsb_pkg::PH_STOPPING;
              cmd.set_dos  = 1'b1;
              res_acc_next = 1'b1;
              res_st_next  = rsb_pkg::ST_OK;
              res_act_next = rsb_pkg::ACT_TERMINATE;
            end
          end
          rsb_pkg::OP_STOP: begin
            if (phase inside {rsb_pkg::PH_STOPPED, rsb_pkg::PH_DISABLED}) begin
              res_acc_next = 1'b1;
              res_st_next  = rsb_pkg::ST_OK;
            end else if (phase == rsb_pkg::PH_BACKOFF) begin
              phase_next    = rsb_pkg::PH_STOPPED;
              cmd.clr_retry = 1'b1;
              cmd.clr_fail  = 1'b1;
              res_acc_next  = 1'b1;
              res_st_next   = rsb_pkg::ST_OK;
            end else if (phase == rsb_pkg::PH_STOPPING) begin
              res_st_next = rsb_pkg::ST_STOPPING;
            end else begin
              phase_next   = rsb_pkg::PH_STOPPING;
              cmd.clr_dos  = 1'b1;
              res_acc_next = 1'b1;
              res_st_next  = rsb_pkg::ST_OK;
              res_act_next = rsb_pkg::ACT_TERMINATE;
            end
          end
          rsb_pkg::OP_EXITED: begin
            if (phase == rsb_pkg::PH_STOPPING) begin
              cmd.clr_run  = 1'b1;
              res_acc_next = 1'b1;
              if (sts.dos) begin
                phase_next  = rsb_pkg::PH_DISABLED;
                cmd.clr_dos = 1'b1;
                res_st_next = rsb_pkg::ST_DISABLED;
              end else begin
                phase_next   = rsb_pkg::PH_STOPPED;
                cmd.clr_fail = 1'b1;
                res_st_next  = rsb_pkg::ST_OK;
              end
            end else if (phase inside {rsb_pkg::PH_STARTING, rsb_pkg::PH_HANDSHAKING,
                                       rsb_pkg::PH_RUNNING}) begin
              // failure: count it, then check the limit in the next step
              cmd.count_fail = 1'b1;
              cmd.clr_run    = 1'b1;
              cmd.stable_clr = (phase == rsb_pkg::PH_RUNNING) && sts.stable_run;
              state_next     = S_LIMIT;
            end
          end
          rsb_pkg::OP_RESET_DISABLED: begin
            if (phase != rsb_pkg::PH_DISABLED) begin
              res_st_next = rsb_pkg::ST_WRONG;
            end else if (!sts.policy_ok) begin
              res_st_next = rsb_pkg::ST_POLICY;
            end else begin
              phase_next    = rsb_pkg::PH_STOPPED;
              cmd.clr_fail  = 1'b1;
              cmd.clr_retry = 1'b1;
              res_acc_next  = 1'b1;
              res_st_next   = rsb_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end
      S_LIMIT: begin
        res_acc_next = 1'b1;
        if (sts.fail_hit) begin
          phase_next    = rsb_pkg::PH_DISABLED;
          cmd.clr_retry = 1'b1;
          res_st_next   = rsb_pkg::ST_DISABLED;
          res_act_next  = rsb_pkg::ACT_NONE;
          state_next    = S_DONE;
        end else begin
          cmd.delay_init = 1'b1;
          state_next     = S_DELAY;
        end
      end
      S_DELAY: begin
        // one doubling per cycle until the count or the cap is reached
        if (sts.delay_done) begin
          cmd.set_retry = 1'b1;
          phase_next    = rsb_pkg::PH_BACKOFF;
          res_st_next   = rsb_pkg::ST_SCHEDULED;
          res_act_next  = rsb_pkg::ACT_RESTART;
          state_next    = S_DONE;
        end else begin
          cmd.delay_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.res_phase = phase;
    cmd.res_acc   = res_acc;
    cmd.res_st    = res_st;
    cmd.res_act   = res_act;
  end

  // state, phase, result codes and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= rsb_pkg::PH_STOPPED;
      res_acc   <= 1'b0;
      res_st    <= rsb_pkg::ST_OK;
      res_act   <= rsb_pkg::ACT_NONE;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      res_acc <= res_acc_next;
      res_st  <= res_st_next;
      res_act <= res_act_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output beat overwritten while held");

  a_take_decide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECIDE))
    else $error("accepted event not decoded next");

  a_limit_disable: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIMIT && sts.fail_hit) |=> (phase == rsb_pkg::PH_DISABLED))
    else $error("crash limit reached without disabling");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |=> $stable(phase))
    else $error("phase changed outside event processing");
`endif

endmodule

// File: verif/rsb_lifecycle_checker.sv
// lifecycle checker for the restart supervisor: predicts each result beat from
// the accepted event and config beats and compares it field by field
// depends on rsb_pkg only; instantiated beside the block by the testbench top
module rsb_lifecycle_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  rsb_pkg::in_item_t                  in_item,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  rsb_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [rsb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rsb_pkg::CFG_BITS-1:0]       cfg_data,
  output int                                 mismatch_count,
  output int                                 awaited_replies
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsb_pkg::*;

  localparam logic [TIME_BITS-1:0]  TIME_TOP  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  // shadow policy registers
  logic [CFG_BITS-1:0]   base_ms;
  logic [CFG_BITS-1:0]   cap_ms;
  logic [CFG_BITS-1:0]   stable_ms;
  logic [LIMIT_BITS-1:0] crash_lim;

  // shadow supervisor state
  phase_t                phase;
  logic [COUNT_BITS-1:0] fail_cnt;
  logic [TIME_BITS-1:0]  retry_at;
  logic                  retry_armed;
  logic [TIME_BITS-1:0]  run_since;
  logic                  run_armed;
  logic                  disable_pending;

  out_item_t predicted_replies[$];
  int        errors = 0;

  function automatic logic policy_valid();
    return base_ms != '0 && cap_ms >= base_ms && crash_lim != '0;
  endfunction

  // base doubled once per prior failure, held at the cap
  function automatic logic [63:0] backoff_delay(input logic [COUNT_BITS-1:0] count);
    logic [63:0] d;
    logic [63:0] cap;
    int          k;
    cap = {32'd0, cap_ms};
    d   = {32'd0, base_ms};
    for (k = 1; k < count && d < cap && d != 0; k++) begin
      if (d > cap / 2)
        d = cap;
      else
        d = (d * 2 < cap) ? d * 2 : cap;
    end
    return d;
  endfunction

  // apply one event to the shadow state and form its result beat
  function automatic out_item_t next_reply(input in_item_t ev);
    logic [TIME_BITS-1:0] now;
    logic [63:0]          d;
    logic [TIME_BITS:0]   sum;
    logic                 acc;
    status_t              st;
    action_t              act;
    out_item_t            r;
    now = ev.now_ms;
    acc = 1'b0;
    st  = ST_WRONG;
    act = ACT_NONE;
    case (ev.opcode)
      OP_START: begin
        if (!policy_valid()) begin
          st = ST_POLICY;
        end else if (phase == PH_BACKOFF && retry_armed && now < retry_at) begin
          st  = ST_PENDING;
          act = ACT_RESTART;
        end else if (phase == PH_STOPPED || phase == PH_BACKOFF) begin
          phase       = PH_STARTING;
          retry_armed = 1'b0;
          retry_at    = '0;
          acc = 1'b1; st = ST_OK; act = ACT_LAUNCH;
        end
      end
      OP_STARTED: begin
        if (phase == PH_STARTING) begin
          phase = PH_HANDSHAKING;
          acc = 1'b1; st = ST_OK; act = ACT_AWAIT;
        end
      end
      OP_HS_OK: begin
        if (phase == PH_HANDSHAKING) begin
          phase     = PH_RUNNING;
          run_since = now;
          run_armed = 1'b1;
          acc = 1'b1; st = ST_OK;
        end
      end
      OP_HS_REJECT: begin
        if (phase == PH_HANDSHAKING) begin
          disable_pending = 1'b1;
          phase           = PH_STOPPING;
          acc = 1'b1; st = ST_OK; act = ACT_TERMINATE;
        end
      end
      OP_STOP: begin
        if (phase == PH_STOPPED || phase == PH_DISABLED) begin
          acc = 1'b1; st = ST_OK;
        end else if (phase == PH_BACKOFF) begin
          phase       = PH_STOPPED;
          retry_armed = 1'b0;
          retry_at    = '0;
          fail_cnt    = '0;
          acc = 1'b1; st = ST_OK;
        end else if (phase == PH_STOPPING) begin
          st = ST_STOPPING;
        end else begin
          disable_pending = 1'b0;
          phase           = PH_STOPPING;
          acc = 1'b1; st = ST_OK; act = ACT_TERMINATE;
        end
      end
      OP_EXITED: begin
        if (phase == PH_STOPPING) begin
          run_armed = 1'b0;
          acc       = 1'b1;
          if (disable_pending) begin
            phase           = PH_DISABLED;
            disable_pending = 1'b0;
            st              = ST_DISABLED;
          end else begin
            phase    = PH_STOPPED;
            fail_cnt = '0;
            st       = ST_OK;
          end
        end else if (phase == PH_STARTING || phase == PH_HANDSHAKING ||
                     phase == PH_RUNNING) begin
          // a long enough run forgives earlier crashes
          if (phase == PH_RUNNING && run_armed && now >= run_since &&
              (now - run_since) >= {16'd0, stable_ms})
            fail_cnt = '0;
          run_armed = 1'b0;
          if (fail_cnt < COUNT_TOP)
            fail_cnt = fail_cnt + 1'b1;
          acc = 1'b1;
          if (fail_cnt >= crash_lim) begin
            phase       = PH_DISABLED;
            retry_armed = 1'b0;
            retry_at    = '0;
            st          = ST_DISABLED;
          end else begin
            d           = backoff_delay(fail_cnt);
            sum         = {1'b0, now} + {1'b0, d[TIME_BITS-1:0]};
            retry_at    = sum[TIME_BITS] ? TIME_TOP : sum[TIME_BITS-1:0];
            retry_armed = 1'b1;
            phase       = PH_BACKOFF;
            st = ST_SCHEDULED; act = ACT_RESTART;
          end
        end
      end
      OP_RESET_DISABLED: begin
        if (phase != PH_DISABLED) begin
          st = ST_WRONG;
        end else if (!policy_valid()) begin
          st = ST_POLICY;
        end else begin
          phase       = PH_STOPPED;
          fail_cnt    = '0;
          retry_armed = 1'b0;
          retry_at    = '0;
          acc = 1'b1; st = ST_OK;
        end
      end
      default: begin
        // undefined code: refused, nothing moves
      end
    endcase
    r.accepted      = acc;
    r.status        = st;
    r.state_now     = phase;
    r.action        = act;
    r.retry_at_ms   = retry_armed ? retry_at : '0;
    r.retry_valid   = retry_armed;
    r.failure_count = fail_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // track config, predict on event beats, compare on result beats
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      base_ms         = 32'd1000;
      cap_ms          = 32'd60000;
      stable_ms       = 32'd30000;
      crash_lim       = 8'd5;
      phase           = PH_STOPPED;
      fail_cnt        = '0;
      retry_at        = '0;
      retry_armed     = 1'b0;
      run_since       = '0;
      run_armed       = 1'b0;
      disable_pending = 1'b0;
      predicted_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:   base_ms   = cfg_data;
          CFG_MAX:    cap_ms    = cfg_data;
          CFG_STABLE: stable_ms = cfg_data;
          CFG_LIMIT:  crash_lim = cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_replies.push_back(next_reply(in_item));
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $error("result beat with no event waiting for it");
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("accepted", want.accepted, out_item.accepted);
          check_field("status", want.status, out_item.status);
          check_field("state_now", want.state_now, out_item.state_now);
          check_field("action", want.action, out_item.action);
          check_field("retry_at_ms", want.retry_at_ms, out_item.retry_at_ms);
          check_field("retry_valid", want.retry_valid, out_item.retry_valid);
          check_field("failure_count", want.failure_count, out_item.failure_count);
        end
      end
    end
    mismatch_count  <= errors;
    awaited_replies <= predicted_replies.size();
  end

endmodule

// File: verif/restart_supervisor_backoff_top_tb.sv
// testbench top for the restart supervisor: drives lifecycle events and policy
// writes, randomizes stalls on both channels and gives the verdict
// depends on rsb_pkg, restart_supervisor_backoff_top and rsb_lifecycle_checker
module restart_supervisor_backoff_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsb_pkg::*;

  localparam logic [2:0]           OP_UNDEFINED    = 3'd7;
  localparam logic [TIME_BITS-1:0] TIME_TOP        = '1;
  localparam int                   LONG_HOLD       = 600;
  localparam int                   WATCHDOG_CYCLES = 5000;
  localparam int                   DRAIN_CYCLES    = 40;
  localparam int                   SETTLE_CYCLES   = 8;
  localparam int                   POLICY_COUNT    = 10;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_item;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_item;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  int mismatch_count;
  int awaited_replies;

  // stimulus knobs shared by the sender and receiver processes
  logic [TIME_BITS-1:0] clock_ms = '0;
  int                   policy_items;
  int                   out_beats = 0;
  int                   quiet_cycles = 0;
  int                   in_idle_pct = 20;
  int                   out_idle_pct = 20;
  bit                   calm = 1'b0;
  bit                   held = 1'b0;

  restart_supervisor_backoff_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsb_lifecycle_checker lifecycle_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .awaited_replies (awaited_replies)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: too long without any beat ends the run
  always @(posedge clk) begin
    if (out_valid && out_ready)
      out_beats <= out_beats + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts plus one long hold-off while events keep coming
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && out_beats >= 200 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // advance the event clock by a mix of short, long and wild steps
  function automatic logic [TIME_BITS-1:0] tick();
    int          mode;
    logic [63:0] r;
    mode = $urandom_range(0, 99);
    r    = {$urandom, $urandom};
    if (mode < 35)
      clock_ms = clock_ms + $urandom_range(0, 63);
    else if (mode < 65)
      clock_ms = clock_ms + $urandom_range(0, 70000);
    else if (mode < 85)
      clock_ms = clock_ms + r[31:0];
    else if (mode < 93)
      clock_ms = clock_ms + r[39:0];
    else if (mode < 97)
      clock_ms = TIME_TOP - $urandom_range(0, 100000);
    else
      clock_ms = r[TIME_BITS-1:0];
    return clock_ms;
  endfunction

  // one event beat, with an optional idle burst ahead of it
  task automatic send_event(input logic [2:0] op, input logic [TIME_BITS-1:0] stamp);
    in_item_t ev;
    ev.opcode = op;
    ev.now_ms = stamp;
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (!in_ready);
    policy_items++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // policy writes only once every result is back and the block has settled
  task automatic program_policy(input logic [CFG_BITS-1:0] base, input logic [CFG_BITS-1:0] cap,
                                input logic [CFG_BITS-1:0] stable,
                                input logic [LIMIT_BITS-1:0] lim);
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_BASE, base);
    write_reg(CFG_MAX, cap);
    write_reg(CFG_STABLE, stable);
    write_reg(CFG_LIMIT, {{(CFG_BITS-LIMIT_BITS){1'b0}}, lim});
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // one lifecycle scenario: mostly well-formed runs, some early retries and noise
  task automatic run_lifecycle();
    int          pick;
    int          n;
    logic [63:0] r;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) begin
      in_idle_pct  = pick_idle_pct();
      out_idle_pct = pick_idle_pct();
    end
    if ($urandom_range(0, 4) == 0)
      send_event(OP_RESET_DISABLED, tick());
    if (pick < 9) begin
      // full run ending in a crash or a clean stop
      send_event(OP_START, tick());
      send_event(OP_STARTED, tick());
      send_event(OP_HS_OK, tick());
      if (pick < 6) begin
        send_event(OP_EXITED, tick());
      end else begin
        send_event(OP_STOP, tick());
        send_event(OP_EXITED, tick());
      end
    end else if (pick < 11) begin
      // rejected handshake leads to disabled
      send_event(OP_START, tick());
      send_event(OP_STARTED, tick());
      send_event(OP_HS_REJECT, tick());
      if ($urandom_range(0, 1) == 1)
        send_event(OP_STOP, tick());
      send_event(OP_EXITED, tick());
    end else if (pick < 14) begin
      // crash before the handshake completes
      send_event(OP_START, tick());
      if ($urandom_range(0, 1) == 1)
        send_event(OP_STARTED, tick());
      send_event(OP_EXITED, tick());
    end else if (pick < 17) begin
      // retry attempt, often too early, then maybe a cancel
      send_event(OP_START, clock_ms + $urandom_range(0, 50));
      send_event(OP_START, tick());
      if ($urandom_range(0, 1) == 1)
        send_event(OP_STOP, tick());
    end else begin
      // noise: any code at any time
      n = $urandom_range(1, 4);
      repeat (n) begin
        r = {$urandom, $urandom};
        send_event(r[50:48], r[TIME_BITS-1:0]);
      end
    end
  endtask

  initial begin
    int               p;
    int               quota;
    logic [CFG_BITS-1:0] b;
    logic [CFG_BITS-1:0] m;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default policy, every event and the corner transitions
    send_event(OP_STOP, '0);
    send_event(OP_UNDEFINED, TIME_TOP);
    send_event(OP_STARTED, 48'd1);
    send_event(OP_START, '0);
    send_event(OP_STARTED, 48'd5);
    send_event(OP_HS_OK, 48'd10);
    send_event(OP_EXITED, 48'd100);
    send_event(OP_START, 48'd500);
    send_event(OP_STOP, 48'd600);
    send_event(OP_START, 48'd700);
    send_event(OP_STARTED, 48'd710);
    send_event(OP_HS_REJECT, 48'd720);
    send_event(OP_STOP, 48'd730);
    send_event(OP_EXITED, 48'd740);
    send_event(OP_STOP, 48'd750);
    send_event(OP_START, 48'd760);
    send_event(OP_RESET_DISABLED, 48'd770);
    send_event(OP_RESET_DISABLED, 48'd780);
    // retry time saturating at the top of the clock
    send_event(OP_START, TIME_TOP - 48'd500);
    send_event(OP_EXITED, TIME_TOP - 48'd10);
    send_event(OP_START, TIME_TOP);
    send_event(OP_STARTED, TIME_TOP);
    send_event(OP_HS_OK, TIME_TOP);
    send_event(OP_STOP, TIME_TOP);
    send_event(OP_EXITED, TIME_TOP);

    // directed: disable on the first crash, then an invalid policy
    program_policy(32'd1, '1, 32'd0, 8'd1);
    send_event(OP_START, 48'd5);
    send_event(OP_EXITED, 48'd6);
    program_policy(32'd0, 32'd1000, 32'd0, 8'd5);
    send_event(OP_RESET_DISABLED, 48'd7);
    send_event(OP_START, 48'd8);

    // random: one block of scenarios per policy setting
    for (p = 0; p < POLICY_COUNT; p++) begin
      quota = 150;
      case (p)
        0: begin program_policy(32'd1000, 32'd60000, 32'd30000, 8'd5); quota = 170; end
        1: begin program_policy(32'd1, '1, 32'd0, 8'd255); quota = 170; end
        2: begin program_policy('1, '1, '1, 8'd1); quota = 170; end
        3: begin program_policy(32'd3, 32'd40, 32'd50, 8'd8); quota = 170; end
        4: begin program_policy(32'd100, 32'd50, 32'd1000, 8'd3); quota = 40; end
        5: begin program_policy(32'd0, 32'd0, 32'd0, 8'd0); quota = 40; end
        default: begin
          case ($urandom_range(0, 2))
            0: begin
              b = $urandom_range(1, 200);
              m = b + $urandom_range(0, 5000);
              program_policy(b, m, $urandom_range(0, 100000),
                             LIMIT_BITS'($urandom_range(1, 12)));
            end
            1: program_policy($urandom, $urandom, $urandom,
                              LIMIT_BITS'($urandom_range(0, 255)));
            default: program_policy($urandom_range(1, 1000), '1, $urandom,
                                    LIMIT_BITS'($urandom_range(2, 40)));
          endcase
        end
      endcase
      calm = (p == POLICY_COUNT - 1);
      policy_items = 0;
      while (policy_items < quota)
        run_lifecycle();
    end

    // drain and give the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_replies == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
